// File: src/ybd_pkg.sv
// ybd_pkg: shared constants, types and lookup functions of the yuyv box downscaler
// no dependencies
`default_nettype none

package ybd_pkg;

  localparam int MaxLineGroups = 2048;
  localparam int MaxScale      = 8;

  localparam int SampleW  = 8;
  localparam int ColW     = $clog2(MaxLineGroups);
  localparam int LineW    = ColW + 1;
  localparam int CntW     = $clog2(MaxScale);
  localparam int ScaleW   = CntW + 1;
  localparam int SumW     = 14;
  localparam int EntryW   = 4 * SumW;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 12;

  // floor(x / n) = (x * ceil(2^14 / n)) >> 14 for x below 4096
  localparam int RecipShift = 14;
  localparam int RecipW     = 15;
  // floor(x / (n*n)) = (x * ceil(2^21 / (n*n))) >> 21 for x below 32768
  localparam int AreaShift  = 21;
  localparam int AreaRecipW = 22;
  localparam int HalfW      = 6;
  localparam int QuotW      = SumW + 1 + AreaRecipW - AreaShift;

  localparam logic [CfgIdxW-1:0] CfgScale = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLine  = 1'd1;

  localparam logic [ScaleW-1:0] ScaleReset = 4'd1;
  localparam logic [LineW-1:0]  LineReset  = 12'd320;

  typedef struct packed {
    logic [ColW-1:0]    col;
    logic               first;
    logic               a_left;
    logic               b_left;
    logic               last_blk;
    logic               eol;
    logic [ScaleW-1:0]  scale;
    logic [SampleW-1:0] ya;
    logic [SampleW-1:0] u;
    logic [SampleW-1:0] yb;
    logic [SampleW-1:0] v;
  } grp_t;

  typedef struct packed {
    logic [SumW-1:0]   sl;
    logic [SumW-1:0]   sr;
    logic [SumW-1:0]   su;
    logic [SumW-1:0]   sv;
    logic [ColW-1:0]   col;
    logic              eol;
    logic [ScaleW-1:0] scale;
  } sum_t;

  function automatic logic [RecipW-1:0] scale_recip(input logic [ScaleW-1:0] n);
    logic [RecipW-1:0] r;
    case (n)
      4'd2:    r = 15'd8192;
      4'd3:    r = 15'd5462;
      4'd4:    r = 15'd4096;
      4'd5:    r = 15'd3277;
      4'd6:    r = 15'd2731;
      4'd7:    r = 15'd2341;
      4'd8:    r = 15'd2048;
      default: r = 15'd16384;
    endcase
    return r;
  endfunction

  function automatic logic [AreaRecipW-1:0] area_recip(input logic [ScaleW-1:0] n);
    logic [AreaRecipW-1:0] r;
    case (n)
      4'd2:    r = 22'd524288;
      4'd3:    r = 22'd233017;
      4'd4:    r = 22'd131072;
      4'd5:    r = 22'd83887;
      4'd6:    r = 22'd58255;
      4'd7:    r = 22'd42800;
      4'd8:    r = 22'd32768;
      default: r = 22'd2097152;
    endcase
    return r;
  endfunction

  function automatic logic [HalfW-1:0] area_half(input logic [ScaleW-1:0] n);
    logic [HalfW-1:0] h;
    case (n)
      4'd2:    h = 6'd2;
      4'd3:    h = 6'd4;
      4'd4:    h = 6'd8;
      4'd5:    h = 6'd12;
      4'd6:    h = 6'd18;
      4'd7:    h = 6'd24;
      4'd8:    h = 6'd32;
      default: h = 6'd0;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

// File: src/ybd_if.sv
// ybd_grp_if and ybd_pair_if: valid/ready channels for input groups and output pairs
// depends on ybd_pkg
`default_nettype none

interface ybd_grp_if;
  logic                        valid;
  logic                        ready;
  logic [ybd_pkg::SampleW-1:0] luma_a;
  logic [ybd_pkg::SampleW-1:0] chroma_u_in;
  logic [ybd_pkg::SampleW-1:0] luma_b;
  logic [ybd_pkg::SampleW-1:0] chroma_v_in;
  logic                        frame_start;

  modport source (output valid, luma_a, chroma_u_in, luma_b, chroma_v_in, frame_start,
                  input ready);
  modport sink (input valid, luma_a, chroma_u_in, luma_b, chroma_v_in, frame_start,
                output ready);
endinterface

interface ybd_pair_if;
  logic                        valid;
  logic                        ready;
  logic [ybd_pkg::SampleW-1:0] luma_left;
  logic [ybd_pkg::SampleW-1:0] luma_right;
  logic [ybd_pkg::SampleW-1:0] chroma_u_out;
  logic [ybd_pkg::SampleW-1:0] chroma_v_out;
  logic [ybd_pkg::ColW-1:0]    out_column;
  logic                        end_of_line;

  modport source (output valid, luma_left, luma_right, chroma_u_out, chroma_v_out,
                  out_column, end_of_line, input ready);
  modport sink (input valid, luma_left, luma_right, chroma_u_out, chroma_v_out,
                out_column, end_of_line, output ready);
endinterface

`default_nettype wire

// File: src/ybd_line_ram.sv
// ybd_line_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`default_nettype none

module ybd_line_ram #(
  parameter int Width = 56,
  parameter int Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/ybd_front.sv
// ybd_front: configuration registers, position counters and column decode per group
// depends on ybd_pkg
`default_nettype none

module ybd_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ybd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [ybd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                            take_i,
  input  wire logic [ybd_pkg::SampleW-1:0]     luma_a_i,
  input  wire logic [ybd_pkg::SampleW-1:0]     chroma_u_i,
  input  wire logic [ybd_pkg::SampleW-1:0]     luma_b_i,
  input  wire logic [ybd_pkg::SampleW-1:0]     chroma_v_i,
  input  wire logic                            frame_start_i,
  output ybd_pkg::grp_t                        grp_o,
  output logic                                 keep_o
);

  localparam int ColProdW = ybd_pkg::ColW + ybd_pkg::RecipW;
  localparam int BlkProdW = ybd_pkg::LineW + ybd_pkg::RecipW;

  logic [ybd_pkg::ScaleW-1:0] scale_q;
  logic [ybd_pkg::LineW-1:0]  line_q;
  logic [ybd_pkg::ColW-1:0]   pos_q, pos_d, pos_c;
  logic [ybd_pkg::CntW-1:0]   gib_q, gib_d, gib_c;
  logic [ybd_pkg::CntW-1:0]   row_q, row_d, row_c;

  logic [ybd_pkg::ScaleW-1:0] n_eff, nm1, p2;
  logic [ybd_pkg::LineW-1:0]  l_eff, blocks, pos_inc;
  logic [ybd_pkg::RecipW-1:0] recip;
  logic [ColProdW-1:0]        col_prod;
  logic [BlkProdW-1:0]        blk_prod;
  logic [ybd_pkg::ColW-1:0]   col;
  logic                       gib_end, row_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ybd_pkg::ScaleReset;
      line_q  <= ybd_pkg::LineReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ybd_pkg::CfgScale: scale_q <= cfg_data_i[ybd_pkg::ScaleW-1:0];
        ybd_pkg::CfgLine:  line_q  <= cfg_data_i[ybd_pkg::LineW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale_q == '0) begin
      n_eff = ybd_pkg::ScaleW'(1);
    end else if (scale_q > ybd_pkg::ScaleW'(ybd_pkg::MaxScale)) begin
      n_eff = ybd_pkg::ScaleW'(ybd_pkg::MaxScale);
    end else begin
      n_eff = scale_q;
    end
    if (line_q == '0) begin
      l_eff = ybd_pkg::LineW'(1);
    end else if (line_q > ybd_pkg::LineW'(ybd_pkg::MaxLineGroups)) begin
      l_eff = ybd_pkg::LineW'(ybd_pkg::MaxLineGroups);
    end else begin
      l_eff = line_q;
    end
  end

  assign pos_c = frame_start_i ? '0 : pos_q;
  assign gib_c = frame_start_i ? '0 : gib_q;
  assign row_c = frame_start_i ? '0 : row_q;

  // divide by n through the reciprocal table
  assign recip    = ybd_pkg::scale_recip(n_eff);
  assign col_prod = ColProdW'(pos_c) * ColProdW'(recip);
  assign blk_prod = BlkProdW'(l_eff) * BlkProdW'(recip);
  assign col      = col_prod[ybd_pkg::RecipShift +: ybd_pkg::ColW];
  assign blocks   = blk_prod[ybd_pkg::RecipShift +: ybd_pkg::LineW];

  assign nm1     = n_eff - ybd_pkg::ScaleW'(1);
  assign gib_end = {1'b0, gib_c} >= nm1;
  assign row_end = {1'b0, row_c} >= nm1;
  assign p2      = {gib_c, 1'b0};

  assign keep_o = {1'b0, col} < blocks;

  always_comb begin
    grp_o.col      = col;
    grp_o.first    = (row_c == '0) && (gib_c == '0);
    grp_o.a_left   = p2 < n_eff;
    grp_o.b_left   = (p2 + ybd_pkg::ScaleW'(1)) < n_eff;
    grp_o.last_blk = row_end && gib_end;
    grp_o.eol      = {1'b0, col} == (blocks - ybd_pkg::LineW'(1));
    grp_o.scale    = n_eff;
    grp_o.ya       = luma_a_i;
    grp_o.u        = chroma_u_i;
    grp_o.yb       = luma_b_i;
    grp_o.v        = chroma_v_i;
  end

  assign pos_inc = {1'b0, pos_c} + ybd_pkg::LineW'(1);

  always_comb begin
    gib_d = gib_end ? '0 : gib_c + ybd_pkg::CntW'(1);
    pos_d = pos_inc[ybd_pkg::ColW-1:0];
    row_d = row_c;
    if (pos_inc >= l_eff) begin
      pos_d = '0;
      gib_d = '0;
      row_d = row_end ? '0 : row_c + ybd_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      gib_q <= '0;
      row_q <= '0;
    end else if (take_i) begin
      pos_q <= pos_d;
      gib_q <= gib_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

// File: src/ybd_accum.sv
// ybd_accum: read-modify-write of the column sums with write forwarding, sum register
// depends on ybd_pkg; drives the ybd_line_ram write ports and takes its read data
`default_nettype none

module ybd_accum (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         take_i,
  input  wire logic                         keep_i,
  input  ybd_pkg::grp_t                     grp_i,
  output logic                              s1_free_o,
  input  wire logic [ybd_pkg::EntryW-1:0]   rdata_i,
  output logic                              ram_we_o,
  output logic      [ybd_pkg::ColW-1:0]     ram_waddr_o,
  output logic      [ybd_pkg::EntryW-1:0]   ram_wdata_o,
  output logic                              sum_valid_o,
  output ybd_pkg::sum_t                     sum_o,
  input  wire logic                         sum_ready_i
);

  ybd_pkg::grp_t s1_q;
  logic          s1_valid_q, s1_valid_d;
  ybd_pkg::sum_t s2_q;
  logic          s2_valid_q, s2_valid_d;

  logic                        wr_valid_q;
  logic [ybd_pkg::ColW-1:0]    wr_col_q;
  logic [ybd_pkg::EntryW-1:0]  wr_data_q;

  logic                        s2_free, s1_fire, s2_load;
  logic [ybd_pkg::EntryW-1:0]  base, entry_new;
  logic [ybd_pkg::SumW-1:0]    sl, sr, su, sv;
  logic [ybd_pkg::SumW-1:0]    ya, yb;

  assign s2_free   = !s2_valid_q || sum_ready_i;
  assign s1_fire   = s1_valid_q && (!s1_q.last_blk || s2_free);
  assign s1_free_o = !s1_valid_q || s1_fire;
  assign s2_load   = s1_fire && s1_q.last_blk;

  // the write of the item just ahead lands at the edge that registers this read
  always_comb begin
    if (s1_q.first) begin
      base = '0;
    end else if (wr_valid_q && (wr_col_q == s1_q.col)) begin
      base = wr_data_q;
    end else begin
      base = rdata_i;
    end
  end

  assign ya = ybd_pkg::SumW'(s1_q.ya);
  assign yb = ybd_pkg::SumW'(s1_q.yb);

  always_comb begin
    sl = base[0 +: ybd_pkg::SumW];
    sr = base[ybd_pkg::SumW +: ybd_pkg::SumW];
    su = base[2*ybd_pkg::SumW +: ybd_pkg::SumW] + ybd_pkg::SumW'(s1_q.u);
    sv = base[3*ybd_pkg::SumW +: ybd_pkg::SumW] + ybd_pkg::SumW'(s1_q.v);
    if (s1_q.a_left) begin
      sl = sl + ya;
    end else begin
      sr = sr + ya;
    end
    if (s1_q.b_left) begin
      sl = sl + yb;
    end else begin
      sr = sr + yb;
    end
  end

  assign entry_new   = {sv, su, sr, sl};
  assign ram_we_o    = s1_fire;
  assign ram_waddr_o = s1_q.col;
  assign ram_wdata_o = entry_new;

  assign s1_valid_d = (take_i && keep_i) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign s2_valid_d = s2_load ? 1'b1 : (sum_ready_i ? 1'b0 : s2_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wr_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      if (s1_fire) begin
        wr_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && keep_i) begin
      s1_q <= grp_i;
    end
    if (s1_fire) begin
      wr_col_q  <= s1_q.col;
      wr_data_q <= entry_new;
    end
    if (s2_load) begin
      s2_q.sl    <= sl;
      s2_q.sr    <= sr;
      s2_q.su    <= su;
      s2_q.sv    <= sv;
      s2_q.col   <= s1_q.col;
      s2_q.eol   <= s1_q.eol;
      s2_q.scale <= s1_q.scale;
    end
  end

  assign sum_valid_o = s2_valid_q;
  assign sum_o       = s2_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> s2_valid_q)
    else $error("finished block sums not registered");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !sum_ready_i) |=> (s2_valid_q && $stable(s2_q)))
    else $error("stalled block sums changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (wr_valid_q && (wr_col_q == $past(s1_q.col))))
    else $error("forwarding register misses last write");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_q)))
    else $error("held group lost in accumulate stage");
`endif

endmodule

`default_nettype wire

// File: src/ybd_average.sv
// ybd_average: rounded box average by reciprocal multiply, saturation, output register
// depends on ybd_pkg and ybd_pair_if
`default_nettype none

module ybd_average (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        sum_valid_i,
  input  ybd_pkg::sum_t    sum_i,
  output logic             sum_ready_o,
  ybd_pair_if.source       pair_o
);

  localparam int NumW  = ybd_pkg::SumW + 1;
  localparam int ProdW = NumW + ybd_pkg::AreaRecipW;

  function automatic logic [ybd_pkg::SampleW-1:0] box_avg(
    input logic [ybd_pkg::SumW-1:0]       s,
    input logic [ybd_pkg::HalfW-1:0]      half,
    input logic [ybd_pkg::AreaRecipW-1:0] recip
  );
    logic [NumW-1:0]              num;
    logic [ProdW-1:0]             prod;
    logic [ybd_pkg::QuotW-1:0]    quo;
    logic [ybd_pkg::SampleW-1:0]  res;
    num  = NumW'(s) + NumW'(half);
    prod = ProdW'(num) * ProdW'(recip);
    quo  = prod[ybd_pkg::AreaShift +: ybd_pkg::QuotW];
    res  = (quo > ybd_pkg::QuotW'(255)) ? '1 : quo[ybd_pkg::SampleW-1:0];
    return res;
  endfunction

  logic                           out_valid_q;
  logic                           out_free, load;
  logic [ybd_pkg::HalfW-1:0]      half;
  logic [ybd_pkg::AreaRecipW-1:0] recip;

  assign out_free    = !out_valid_q || pair_o.ready;
  assign sum_ready_o = out_free;
  assign load        = sum_valid_i && out_free;
  assign half        = ybd_pkg::area_half(sum_i.scale);
  assign recip       = ybd_pkg::area_recip(sum_i.scale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= sum_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pair_o.luma_left    <= box_avg(sum_i.sl, half, recip);
      pair_o.luma_right   <= box_avg(sum_i.sr, half, recip);
      pair_o.chroma_u_out <= box_avg(sum_i.su, half, recip);
      pair_o.chroma_v_out <= box_avg(sum_i.sv, half, recip);
      pair_o.out_column   <= sum_i.col;
      pair_o.end_of_line  <= sum_i.eol;
    end
  end

  assign pair_o.valid = out_valid_q;

endmodule

`default_nettype wire

// File: src/yuyv_box_downscale_to_planar_unit.sv
// yuyv_box_downscale_to_planar_unit: top level of the yuyv 4:2:2 box downscaler
// depends on ybd_pkg, ybd_if, ybd_front, ybd_line_ram, ybd_accum, ybd_average
//
//   channel  dir  word                                      handshake
//   grp_i    in   luma_a, chroma_u_in, luma_b, chroma_v_in,  valid/ready
//                 frame_start
//   pair_o   out  luma_left, luma_right, chroma_u_out,       valid/ready
//                 chroma_v_out, out_column, end_of_line
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i            write enable
//
// one group per cycle sustained while the output is not stalled, set by the line memory:
// one read and one write per cycle, with the last write forwarded to the next read of the
// same column; a block's last group passes the accumulate, sum and output registers
// reset sets the format and clears counters and valid flags; line memory needs no clearing
// a stalled output holds up to three words in flight before grp_i.ready drops
`default_nettype none

module yuyv_box_downscale_to_planar_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ybd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ybd_pkg::CfgDataW-1:0] cfg_data_i,
  ybd_grp_if.sink                           grp_i,
  ybd_pair_if.source                        pair_o
);

  logic                         take, keep, s1_free;
  ybd_pkg::grp_t                grp;
  logic                         ram_we;
  logic [ybd_pkg::ColW-1:0]     ram_waddr;
  logic [ybd_pkg::EntryW-1:0]   ram_wdata, ram_rdata;
  logic                         sum_valid, sum_ready;
  ybd_pkg::sum_t                sum;

  assign grp_i.ready = s1_free;
  assign take        = grp_i.valid && s1_free;

  ybd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .take_i        (take),
    .luma_a_i      (grp_i.luma_a),
    .chroma_u_i    (grp_i.chroma_u_in),
    .luma_b_i      (grp_i.luma_b),
    .chroma_v_i    (grp_i.chroma_v_in),
    .frame_start_i (grp_i.frame_start),
    .grp_o         (grp),
    .keep_o        (keep)
  );

  ybd_line_ram #(
    .Width (ybd_pkg::EntryW),
    .Depth (ybd_pkg::MaxLineGroups)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (take),
    .raddr_i (grp.col),
    .rdata_o (ram_rdata)
  );

  ybd_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .keep_i      (keep),
    .grp_i       (grp),
    .s1_free_o   (s1_free),
    .rdata_i     (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .sum_valid_o (sum_valid),
    .sum_o       (sum),
    .sum_ready_i (sum_ready)
  );

  ybd_average u_average (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sum_i       (sum),
    .sum_ready_o (sum_ready),
    .pair_o      (pair_o)
  );

endmodule

`default_nettype wire

// File: test/tb_yuyv_box_downscale_to_planar_unit.sv
`timescale 1ns / 100ps
// tb_yuyv_box_downscale_to_planar_unit: self-checking bench for the yuyv box downscaler
// a directed table, then random frames, each pair word checked against a box-average model
// or the fixed word of a typed row; depends on ybd_pkg, ybd_if and the downscaler rtl

module tb_yuyv_box_downscale_to_planar_unit;
  import ybd_pkg::*;

  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 200;
  localparam int RandomGroups = 1100;
  localparam int PhaseCap     = 240;

  typedef struct packed {
    logic [SampleW-1:0] luma_a;
    logic [SampleW-1:0] chroma_u;
    logic [SampleW-1:0] luma_b;
    logic [SampleW-1:0] chroma_v;
    logic               frame_start;
  } grp_word_t;

  typedef struct packed {
    logic [SampleW-1:0] luma_left;
    logic [SampleW-1:0] luma_right;
    logic [SampleW-1:0] chroma_u;
    logic [SampleW-1:0] chroma_v;
    logic [ColW-1:0]    column;
    logic               end_of_line;
  } pair_word_t;

  typedef enum logic {ROW_FORMAT, ROW_GROUP} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CfgDataW-1:0] scale_data;
    logic [CfgDataW-1:0] line_data;
    grp_word_t           word;
    bit                  typed;
    bit                  yields;
    pair_word_t          pair;
  } stim_row_t;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  ybd_grp_if  grp_ch ();
  ybd_pair_if pair_ch ();

  yuyv_box_downscale_to_planar_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .grp_i      (grp_ch),
    .pair_o     (pair_ch)
  );

  // box-average model state
  logic [SumW-1:0]     sum_left  [MaxLineGroups];
  logic [SumW-1:0]     sum_right [MaxLineGroups];
  logic [SumW-1:0]     sum_u     [MaxLineGroups];
  logic [SumW-1:0]     sum_v     [MaxLineGroups];
  bit                  sum_written [MaxLineGroups];
  int unsigned         grp_pos;
  int unsigned         grp_in_blk;
  int unsigned         band_row;
  logic [ScaleW-1:0]   scale_reg = ScaleReset;
  logic [CfgDataW-1:0] line_reg  = LineReset;

  pair_word_t expected_pairs [$];
  stim_row_t  directed_rows [$];
  int failures;
  int groups_sent;
  int directed_groups;
  int random_groups;
  int pairs_checked;
  int formats_set;
  int hold_requests;
  int holds_done;
  bit burst;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $error("timeout with %0d pair words outstanding", expected_pairs.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned box_size(logic [ScaleW-1:0] s);
    int unsigned n;
    n = s;
    if (n == 0) n = 1;
    if (n > MaxScale) n = MaxScale;
    return n;
  endfunction

  function automatic int unsigned line_len(logic [CfgDataW-1:0] l);
    int unsigned g;
    g = l;
    if (g == 0) g = 1;
    if (g > MaxLineGroups) g = MaxLineGroups;
    return g;
  endfunction

  function automatic logic [SampleW-1:0] box_mean(logic [SumW-1:0] sum, int unsigned n);
    int unsigned area;
    int unsigned q;
    area = n * n;
    q = (sum + area / 2) / area;
    return (q > 255) ? 8'hFF : q[SampleW-1:0];
  endfunction

  // true when this word would pick up a line memory entry never written
  function automatic bit reads_blank(logic fs);
    int unsigned n;
    int unsigned col;
    if (fs || (band_row == 0 && grp_in_blk == 0)) return 1'b0;
    n = box_size(scale_reg);
    col = grp_pos / n;
    return col < line_len(line_reg) / n && !sum_written[col];
  endfunction

  function automatic bit downscale_group(input grp_word_t w, output pair_word_t p);
    int unsigned     n;
    int unsigned     l;
    int unsigned     blocks;
    int unsigned     col;
    int unsigned     slot;
    logic [SumW-1:0] sl;
    logic [SumW-1:0] sr;
    logic [SumW-1:0] su;
    logic [SumW-1:0] sv;
    bit              hit;
    n = box_size(scale_reg);
    l = line_len(line_reg);
    hit = 1'b0;
    p = '0;
    if (w.frame_start) begin
      grp_pos = 0;
      grp_in_blk = 0;
      band_row = 0;
    end
    blocks = l / n;
    col = grp_pos / n;
    if (col < blocks) begin
      if (band_row == 0 && grp_in_blk == 0) begin
        sl = '0; sr = '0; su = '0; sv = '0;
      end else begin
        sl = sum_left[col]; sr = sum_right[col]; su = sum_u[col]; sv = sum_v[col];
      end
      slot = 2 * grp_in_blk;
      if (slot < n) sl += w.luma_a; else sr += w.luma_a;
      if (slot + 1 < n) sl += w.luma_b; else sr += w.luma_b;
      su += w.chroma_u;
      sv += w.chroma_v;
      sum_left[col] = sl; sum_right[col] = sr; sum_u[col] = su; sum_v[col] = sv;
      sum_written[col] = 1'b1;
      if (band_row >= n - 1 && grp_in_blk >= n - 1) begin
        hit = 1'b1;
        p.luma_left   = box_mean(sl, n);
        p.luma_right  = box_mean(sr, n);
        p.chroma_u    = box_mean(su, n);
        p.chroma_v    = box_mean(sv, n);
        p.column      = col[ColW-1:0];
        p.end_of_line = (col == blocks - 1);
      end
    end
    grp_in_blk = (grp_in_blk >= n - 1) ? 0 : grp_in_blk + 1;
    grp_pos++;
    if (grp_pos >= l) begin
      grp_pos = 0;
      grp_in_blk = 0;
      band_row = (band_row >= n - 1) ? 0 : band_row + 1;
    end
    return hit;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SampleW-1:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return SampleW'($urandom_range(0, 255));
  endfunction

  function automatic stim_row_t fmt_row(logic [CfgDataW-1:0] s, logic [CfgDataW-1:0] l);
    stim_row_t r;
    r = '{kind: ROW_FORMAT, scale_data: s, line_data: l, word: '0, typed: 1'b0,
          yields: 1'b0, pair: '0};
    return r;
  endfunction

  function automatic stim_row_t grp_row(grp_word_t w);
    stim_row_t r;
    r = '{kind: ROW_GROUP, scale_data: '0, line_data: '0, word: w, typed: 1'b0,
          yields: 1'b0, pair: '0};
    return r;
  endfunction

  function automatic stim_row_t typed_row(grp_word_t w, bit y, pair_word_t p);
    stim_row_t r;
    r = '{kind: ROW_GROUP, scale_data: '0, line_data: '0, word: w, typed: 1'b1,
          yields: y, pair: p};
    return r;
  endfunction

  function automatic void check_field(string name, logic [ColW-1:0] want,
                                      logic [ColW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  task automatic settle();
    grp_ch.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_format(input logic [CfgDataW-1:0] s, input logic [CfgDataW-1:0] l);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgScale;
    cfg_data <= s;
    @(posedge clk_i);
    cfg_idx  <= CfgLine;
    cfg_data <= l;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    scale_reg = s[ScaleW-1:0];
    line_reg = l;
    formats_set++;
  endtask

  task automatic push_group(input grp_word_t w, input bit typed = 1'b0,
                            input bit yields = 1'b0, input pair_word_t fixed = '0);
    int         gap;
    bit         hit;
    pair_word_t calc;
    gap = burst ? 0 : pick_gap();
    if (gap != 0) begin
      grp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (reads_blank(w.frame_start)) w.frame_start = 1'b1;
    grp_ch.valid       <= 1'b1;
    grp_ch.luma_a      <= w.luma_a;
    grp_ch.chroma_u_in <= w.chroma_u;
    grp_ch.luma_b      <= w.luma_b;
    grp_ch.chroma_v_in <= w.chroma_v;
    grp_ch.frame_start <= w.frame_start;
    do @(posedge clk_i); while (!grp_ch.ready);
    hit = downscale_group(w, calc);
    if (typed) begin
      if (yields) expected_pairs.push_back(fixed);
    end else if (hit) begin
      expected_pairs.push_back(calc);
    end
    groups_sent++;
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] s, input logic [CfgDataW-1:0] l,
                           input int count, input bit fresh, input bit hold);
    grp_word_t w;
    set_format(s, l);
    if (hold) hold_requests++;
    burst = hold || ($urandom_range(0, 4) == 0);
    for (int i = 0; i < count; i++) begin
      w.luma_a      = rand_byte();
      w.chroma_u    = rand_byte();
      w.luma_b      = rand_byte();
      w.chroma_v    = rand_byte();
      w.frame_start = (i == 0 && fresh) || ($urandom_range(0, 49) == 0);
      push_group(w);
    end
    burst = 1'b0;
    random_groups += count;
  endtask

  // output side pacing, with a long hold whenever one is requested
  initial begin
    int stall;
    int run;
    pair_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_requests != holds_done) begin
        pair_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holds_done++;
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          pair_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        pair_ch.ready <= 1'b1;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : pair_check
    pair_word_t got;
    pair_word_t want;
    if (rst_ni && pair_ch.valid && pair_ch.ready) begin
      got = '{pair_ch.luma_left, pair_ch.luma_right, pair_ch.chroma_u_out,
              pair_ch.chroma_v_out, pair_ch.out_column, pair_ch.end_of_line};
      if (expected_pairs.size() == 0) begin
        $error("pair word with none expected: column %0d", got.column);
        failures++;
      end else begin
        want = expected_pairs.pop_front();
        check_field("luma_left", want.luma_left, got.luma_left);
        check_field("luma_right", want.luma_right, got.luma_right);
        check_field("chroma_u_out", want.chroma_u, got.chroma_u);
        check_field("chroma_v_out", want.chroma_v, got.chroma_v);
        check_field("out_column", want.column, got.column);
        check_field("end_of_line", want.end_of_line, got.end_of_line);
        pairs_checked++;
      end
    end
  end

  initial begin
    int unsigned         n;
    int unsigned         lg;
    int                  count;
    logic [CfgDataW-1:0] s;
    logic [CfgDataW-1:0] l;
    grp_ch.valid       <= 1'b0;
    grp_ch.luma_a      <= '0;
    grp_ch.chroma_u_in <= '0;
    grp_ch.luma_b      <= '0;
    grp_ch.chroma_v_in <= '0;
    grp_ch.frame_start <= 1'b0;

    directed_rows = '{
      // reset format: plain deinterleave, 320 groups per line
      typed_row('{8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1}, 1'b1,
                '{8'h00, 8'hFF, 8'hFF, 8'h00, 11'd0, 1'b0}),
      typed_row('{8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0}, 1'b1,
                '{8'hFF, 8'h00, 8'h00, 8'hFF, 11'd1, 1'b0}),
      // zero box size and zero line length both act as one
      fmt_row(12'h000, 12'h000),
      typed_row('{8'h12, 8'h34, 8'h56, 8'h78, 1'b1}, 1'b1,
                '{8'h12, 8'h56, 8'h34, 8'h78, 11'd0, 1'b1}),
      typed_row('{8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b0}, 1'b1,
                '{8'h9A, 8'hDE, 8'hBC, 8'hF0, 11'd0, 1'b1}),
      // 2x2 boxes on a five group line, last group of each line dropped
      fmt_row(12'h002, 12'd5),
      grp_row('{8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1}),
      grp_row('{8'h01, 8'h80, 8'h02, 8'h7F, 1'b0}),
      grp_row('{8'h10, 8'h20, 8'h30, 8'h40, 1'b0}),
      grp_row('{8'hFE, 8'hFD, 8'hFC, 8'hFB, 1'b0}),
      grp_row('{8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0}),
      grp_row('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}),
      grp_row('{8'h00, 8'h00, 8'h00, 8'h01, 1'b0}),
      grp_row('{8'h11, 8'h22, 8'h33, 8'h44, 1'b0}),
      grp_row('{8'h80, 8'h7F, 8'h81, 8'h7E, 1'b0}),
      grp_row('{8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0}),
      // odd 3x3 box, junk above the scale field
      fmt_row(12'hF03, 12'd3),
      grp_row('{8'h10, 8'h20, 8'h30, 8'h40, 1'b1}),
      grp_row('{8'h50, 8'h60, 8'h70, 8'h80, 1'b0}),
      grp_row('{8'h90, 8'hA0, 8'hB0, 8'hC0, 1'b0}),
      grp_row('{8'hFF, 8'h00, 8'h01, 8'hFE, 1'b0}),
      grp_row('{8'h02, 8'h03, 8'h04, 8'h05, 1'b0}),
      grp_row('{8'hF0, 8'hE0, 8'hD0, 8'hC0, 1'b0}),
      grp_row('{8'h7F, 8'h80, 8'h7F, 8'h80, 1'b0}),
      grp_row('{8'h0F, 8'hF0, 8'h0F, 8'hF0, 1'b0}),
      grp_row('{8'h33, 8'hCC, 8'h66, 8'h99, 1'b0}),
      // box size clamps to eight, line shorter than one box never yields
      fmt_row(12'h00F, 12'd4),
      typed_row('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b0, '0),
      typed_row('{8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0}, 1'b0, '0)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_FORMAT) begin
        set_format(directed_rows[i].scale_data, directed_rows[i].line_data);
      end else begin
        push_group(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].yields,
                   directed_rows[i].pair);
        directed_groups++;
      end
    end

    // oversized line clamps to the maximum, then the long output hold
    run_phase(12'h001, 12'hFFF, 260, 1'b1, 1'b0);
    run_phase(12'h001, 12'd2048, 300, 1'b1, 1'b1);

    while (random_groups < RandomGroups) begin
      s = CfgDataW'($urandom);
      s[ScaleW-1:0] = ($urandom_range(0, 6) == 0) ? ScaleW'($urandom_range(0, 15))
                                                  : ScaleW'($urandom_range(1, MaxScale));
      n = box_size(s[ScaleW-1:0]);
      if ($urandom_range(0, 9) == 0) l = CfgDataW'($urandom);
      else l = CfgDataW'(n * $urandom_range(1, 4) + $urandom_range(0, n - 1));
      lg = line_len(l);
      count = lg * n * $urandom_range(1, 3);
      if (count > PhaseCap) count = PhaseCap;
      run_phase(s, l, count, $urandom_range(0, 3) != 0, 1'b0);
    end

    settle();
    $display("%0d groups sent (%0d from the table) over %0d formats, %0d pair words checked",
             groups_sent, directed_groups, formats_set, pairs_checked);
    $display("box sizes 1 to %0d with clamping, lines up to %0d groups, one long output hold",
             MaxScale, MaxLineGroups);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: yuyv_box_downscale_to_planar_unit.f
src/ybd_pkg.sv
src/ybd_if.sv
src/ybd_line_ram.sv
src/ybd_front.sv
src/ybd_accum.sv
src/ybd_average.sv
src/yuyv_box_downscale_to_planar_unit.sv
test/tb_yuyv_box_downscale_to_planar_unit.sv
